@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console cell writer
// Screen geometry, command codes, control codes and the command/status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Screen geometry (both dimensions powers of two in this build)
   localparam int ROWS      = 32;
   localparam int COLS_N    = 128;
   localparam int ROW_W     = 5;
   localparam int COL_W     = 7;
   localparam int CHAR_W    = 8;
   localparam int OP_W      = 3;
   localparam int DEPTH     = ROWS * COLS_N;
   localparam int ADDR_W    = $clog2(DEPTH);

   // Command codes
   localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
   localparam logic [OP_W-1:0] OP_MOVE   = 3'd1;
   localparam logic [OP_W-1:0] OP_READ   = 3'd2;
   localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLREOL = 3'd4;
   localparam logic [OP_W-1:0] OP_CLRBOT = 3'd5;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h00;

   localparam int TAB_SPAN = 8;
   localparam int TAB_MASK = 7;

   // Controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SWEEP
   } state_type;

   // How a request is carried out
   typedef enum logic [1:0] {
      CLS_IMM,
      CLS_READ,
      CLS_SWEEP,
      CLS_NEWLINE
   } cls_type;

   // Controller to datapath
   typedef struct packed {
      logic apply_imm;
      logic sweep_start;
      logic sweep_step;
      logic load_read;
      logic load_sweep;
      logic nl_advance;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sweep_last;
   } sts_type;

   // Sort a request by the work it needs
   function automatic cls_type op_class(input logic [OP_W-1:0] op,
                                        input logic [CHAR_W-1:0] ch);
      cls_type cls;
      case (op)
         OP_PUT:    cls = (ch == CH_NEWLINE) ? CLS_NEWLINE : CLS_IMM;
         OP_READ:   cls = CLS_READ;
         OP_ERASE:  cls = CLS_SWEEP;
         OP_CLREOL: cls = CLS_SWEEP;
         OP_CLRBOT: cls = CLS_SWEEP;
         default:   cls = CLS_IMM;
      endcase
      return cls;
   endfunction

endpackage

@@ rtl/core/text_console_cell_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_writer: character-cell text screen with a cursor
// Executes put, move, read, erase, clear-to-end-of-line and clear-to-bottom
// requests on a 32 x 128 byte screen store; one result per request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_      in         req_valid/ready    op, row, col, char_code
//  rsp_      out        rsp_valid/ready    cell_value, cursor_row, cursor_col
//
//  Put (other than newline), move and unused codes load the result directly;
//  read first registers the memory read, then loads it. Newline and clear to
//  end of line sweep from the cursor to the end of the row; clear to bottom
//  to the end of the screen; erase the whole screen, all set by the single
//  memory write port, one cell a cycle. After reset a clearing pass runs
//  before the first request. A request is taken while a finished result is
//  being collected; a stalled result holds off the next request.
// ----------------------------------------------------------------------------
module text_console_cell_writer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tcw_pkg::OP_W-1:0]    req_op,
   input  logic [tcw_pkg::ROW_W-1:0]   req_row,
   input  logic [tcw_pkg::COL_W-1:0]   req_col,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tcw_pkg::CHAR_W-1:0]  rsp_cell_value,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col
);
   import tcw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   tcw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   // Cursor, store and result
   tcw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_char_code  (req_char_code),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

@@ rtl/core/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl: request sequencer of the text console cell writer
// Runs the start-up clearing pass, takes requests, steps fill sweeps and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [tcw_pkg::OP_W-1:0]  req_op,
   input  logic [tcw_pkg::CHAR_W-1:0] req_char_code,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  tcw_pkg::sts_type          sts,
   output tcw_pkg::cmd_type          cmd
);
   import tcw_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      pend_nl_ff, pend_nl_in;
   logic      accept;
   cls_type   cls;

   assign cls = op_class(req_op, req_char_code);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (cls)
                  CLS_READ:    state_in = ST_READ;
                  CLS_SWEEP:   state_in = ST_SWEEP;
                  CLS_NEWLINE: state_in = ST_SWEEP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:  state_in = ST_IDLE;
         ST_SWEEP: begin
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         default:  state_in = ST_INIT;
      endcase
   end

   // Outputs and commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            accept    = req_valid && req_ready;
            if (accept) begin
               cmd.apply_imm   = (cls == CLS_IMM);
               cmd.sweep_start = (cls == CLS_SWEEP) || (cls == CLS_NEWLINE);
            end
         end
         ST_READ: begin
            cmd.load_read = 1'b1;
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               cmd.load_sweep = 1'b1;
               cmd.nl_advance = pend_nl_ff;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Result valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.apply_imm || cmd.load_read || cmd.load_sweep) rsp_valid_in = 1'b1;
      pend_nl_in = pend_nl_ff;
      if (accept) pend_nl_in = (cls == CLS_NEWLINE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         pend_nl_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_nl_ff   <= pend_nl_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, screen store and result register
// Holds the cursor, the cell memory with its fill sweep address, and the
// registered result fields.
// ----------------------------------------------------------------------------
module tcw_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tcw_pkg::OP_W-1:0]    req_op,
   input  logic [tcw_pkg::ROW_W-1:0]   req_row,
   input  logic [tcw_pkg::COL_W-1:0]   req_col,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
   output logic [tcw_pkg::CHAR_W-1:0]  rsp_cell_value,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   input  tcw_pkg::cmd_type            cmd,
   output tcw_pkg::sts_type            sts
);
   import tcw_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS_N - 1);

   logic [CHAR_W-1:0] mem [DEPTH];

   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ADDR_W-1:0] swp_addr_ff, swp_addr_in;
   logic [ADDR_W-1:0] swp_end_ff, swp_end_in;
   logic [CHAR_W-1:0] swp_fill_ff, swp_fill_in;
   logic [CHAR_W-1:0] rd_data_ff;
   logic [CHAR_W-1:0] cell_ff, cell_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;

   logic [ADDR_W-1:0] row_base, cur_addr, row_end;
   logic [ROW_W-1:0]  next_row;
   logic [COL_W:0]    col_inc, tab_sum;
   logic [ROW_W-1:0]  imm_row;
   logic [COL_W-1:0]  imm_col;
   logic              imm_wr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CHAR_W-1:0] wr_data;

   // Cursor address and the end of its row
   assign row_base = ADDR_W'(ADDR_W'(cur_row_ff) * ADDR_W'(COLS_N));
   assign cur_addr = row_base + ADDR_W'(cur_col_ff);
   assign row_end  = row_base + ADDR_W'(COLS_N - 1);
   assign next_row = (cur_row_ff == LAST_ROW) ? '0 : cur_row_ff + 1'b1;

   assign col_inc = {1'b0, cur_col_ff} + 1'b1;
   assign tab_sum = {1'b0, cur_col_ff & ~COL_W'(TAB_MASK)} + (COL_W+1)'(TAB_SPAN);

   // Cursor update for requests applied without a sweep or a read
   always_comb begin
      imm_row = cur_row_ff;
      imm_col = cur_col_ff;
      imm_wr  = 1'b0;
      case (req_op)
         OP_PUT: begin
            if (req_char_code == CH_TAB) begin
               if (cur_col_ff < LAST_COL) begin
                  imm_col = (tab_sum > (COL_W+1)'(COLS_N - 1)) ? LAST_COL
                                                             : tab_sum[COL_W-1:0];
               end
            end else if (req_char_code == CH_BACKSPACE) begin
               if (cur_col_ff != '0) imm_col = cur_col_ff - 1'b1;
            end else begin
               imm_wr = 1'b1;
               if (col_inc >= (COL_W+1)'(COLS_N)) begin
                  imm_col = '0;
                  imm_row = next_row;
               end else begin
                  imm_col = col_inc[COL_W-1:0];
               end
            end
         end
         OP_MOVE: begin
            imm_row = ({1'b0, req_row} < (ROW_W+1)'(ROWS)) ? req_row : LAST_ROW;
            imm_col = ({1'b0, req_col} < (COL_W+1)'(COLS_N)) ? req_col : LAST_COL;
         end
         default: begin
            imm_wr = 1'b0;
         end
      endcase
   end

   // Sweep bounds, cursor and result
   always_comb begin
      swp_addr_in = swp_addr_ff;
      swp_end_in  = swp_end_ff;
      swp_fill_in = swp_fill_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      cell_in     = cell_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      if (cmd.sweep_start) begin
         swp_fill_in = CH_SPACE;
         case (req_op)
            OP_ERASE: begin
               swp_addr_in = '0;
               swp_end_in  = LAST_ADDR;
            end
            OP_CLRBOT: begin
               swp_addr_in = cur_addr;
               swp_end_in  = LAST_ADDR;
            end
            default: begin
               swp_addr_in = cur_addr;
               swp_end_in  = row_end;
            end
         endcase
      end else if (cmd.sweep_step) begin
         swp_addr_in = swp_addr_ff + 1'b1;
      end
      if (cmd.apply_imm) begin
         cur_row_in = imm_row;
         cur_col_in = imm_col;
         cell_in    = CH_ZERO;
         out_row_in = imm_row;
         out_col_in = imm_col;
      end
      if (cmd.load_read) begin
         cell_in    = rd_data_ff;
         out_row_in = cur_row_ff;
         out_col_in = cur_col_ff;
      end
      if (cmd.load_sweep) begin
         cell_in    = CH_ZERO;
         out_row_in = cur_row_ff;
         out_col_in = cur_col_ff;
         if (cmd.nl_advance) begin
            cur_row_in = next_row;
            cur_col_in = '0;
            out_row_in = next_row;
            out_col_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         swp_addr_ff <= '0;
         swp_end_ff  <= LAST_ADDR;
         swp_fill_ff <= CH_ZERO;
      end else begin
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         swp_addr_ff <= swp_addr_in;
         swp_end_ff  <= swp_end_in;
         swp_fill_ff <= swp_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff    <= cell_in;
      out_row_ff <= out_row_in;
      out_col_ff <= out_col_in;
   end

   // Single write port: character store or sweep fill
   assign wr_en   = (cmd.apply_imm && imm_wr) || cmd.sweep_step;
   assign wr_addr = cmd.sweep_step ? swp_addr_ff : cur_addr;
   assign wr_data = cmd.sweep_step ? swp_fill_ff : req_char_code;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[cur_addr];
   end

   assign sts.sweep_last = (swp_addr_ff == swp_end_ff);

   assign rsp_cell_value = cell_ff;
   assign rsp_cursor_row = out_row_ff;
   assign rsp_cursor_col = out_col_ff;

endmodule

@@ tb/tb_text_console_cell_writer.sv @@
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer: self-checking bench for the text console
// Drives put, move, read, erase and clear requests into the console and
// predicts every result from a behavioural copy of the screen and cursor.
// Each result is matched in order against its prediction. Directed
// requests cover the edge cases; random traffic follows under several
// idle and stall mixes, plus a long output hold-off.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer;
   import tcw_pkg::*;

   // Spare command codes, ignored by the console
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [CHAR_W-1:0] value;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } console_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [OP_W-1:0]    req_op;
   logic [ROW_W-1:0]   req_row;
   logic [COL_W-1:0]   req_col;
   logic [CHAR_W-1:0]  req_char_code;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [CHAR_W-1:0]  rsp_cell_value;
   logic [ROW_W-1:0]   rsp_cursor_row;
   logic [COL_W-1:0]   rsp_cursor_col;

   // Behavioural screen, cursor and pending results
   logic [CHAR_W-1:0]  screen_model [DEPTH];
   int                 model_row;
   int                 model_col;
   console_result_type pending_results[$];

   int mismatch_count;
   int req_idle_pct;
   int rsp_stall_pct;
   int long_hold_requests;
   int erase_budget;
   int clrbot_budget;

   text_console_cell_writer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up on a hung run
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- model

   // Blank one row from a column to the right edge
   function automatic void blank_row_from(input int row, input int col);
      for (int c = col; c < COLS_N; c++)
         screen_model[row * COLS_N + c] = CH_SPACE;
   endfunction

   // Return to column 0 of the next row, wrapping at the bottom
   function automatic void advance_row();
      model_col = 0;
      model_row = (model_row + 1 >= ROWS) ? 0 : model_row + 1;
   endfunction

   function automatic void put_model_char(input logic [CHAR_W-1:0] ch);
      if (ch == CH_TAB) begin
         // advance to the next tab stop, held at the last column
         for (int i = 0; i < TAB_SPAN; i++) begin
            if (model_col >= COLS_N - 1)
               break;
            model_col++;
            if ((model_col & TAB_MASK) == 0)
               break;
         end
      end else if (ch == CH_NEWLINE) begin
         blank_row_from(model_row, model_col);
         advance_row();
      end else if (ch == CH_BACKSPACE) begin
         if (model_col > 0)
            model_col--;
      end else begin
         screen_model[model_row * COLS_N + model_col] = ch;
         model_col++;
         if (model_col >= COLS_N)
            advance_row();
      end
   endfunction

   // Apply one request to the model and return the result it yields
   function automatic console_result_type predict_console(input logic [OP_W-1:0] op,
                                                          input logic [ROW_W-1:0] row,
                                                          input logic [COL_W-1:0] col,
                                                          input logic [CHAR_W-1:0] ch);
      console_result_type res;
      res = '0;
      case (op)
         OP_PUT:    put_model_char(ch);
         OP_MOVE: begin
            model_row = (row < ROWS) ? row : ROWS - 1;
            model_col = (col < COLS_N) ? col : COLS_N - 1;
         end
         OP_READ:   res.value = screen_model[model_row * COLS_N + model_col];
         OP_ERASE: begin
            for (int a = 0; a < DEPTH; a++)
               screen_model[a] = CH_SPACE;
         end
         OP_CLREOL: blank_row_from(model_row, model_col);
         OP_CLRBOT: begin
            blank_row_from(model_row, model_col);
            for (int r = model_row + 1; r < ROWS; r++)
               blank_row_from(r, 0);
         end
         default: ;
      endcase
      res.row = ROW_W'(model_row);
      res.col = COL_W'(model_col);
      return res;
   endfunction

   // ------------------------------------------------------------ checking

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // Match each collected result against the oldest prediction
   always @(posedge clock) begin
      console_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no request pending, value %0h row %0d col %0d",
                     $time, rsp_cell_value, rsp_cursor_row, rsp_cursor_col);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("cell_value", 32'(want.value), 32'(rsp_cell_value));
            check_field("cursor_row", 32'(want.row), 32'(rsp_cursor_row));
            check_field("cursor_col", 32'(want.col), 32'(rsp_cursor_col));
         end
      end
   end

   // Result side: random stalls, plus a long hold-off on demand
   initial begin
      int hold_left;
      int holds_seen;
      rsp_ready  = 1'b0;
      hold_left  = 0;
      holds_seen = 0;
      forever begin
         @(negedge clock);
         if (holds_seen != long_hold_requests) begin
            holds_seen = long_hold_requests;
            hold_left  = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------ stimulus

   // Offer one request at a falling edge and hold it until taken
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] col,
                               input logic [CHAR_W-1:0] ch);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_row       <= row;
      req_col       <= col;
      req_char_code <= ch;
      do
         @(posedge clock);
      while (!req_ready);
      pending_results.push_back(predict_console(op, row, col, ch));
      @(negedge clock);
   endtask

   task automatic put_req(input logic [CHAR_W-1:0] ch);
      send_request(OP_PUT, ROW_W'($urandom_range(ROWS - 1)),
                   COL_W'($urandom_range(COLS_N - 1)), ch);
   endtask

   task automatic move_req(input int row, input int col);
      send_request(OP_MOVE, ROW_W'(row), COL_W'(col), CHAR_W'($urandom_range(255)));
   endtask

   task automatic plain_req(input logic [OP_W-1:0] op);
      send_request(op, ROW_W'($urandom_range(ROWS - 1)), COL_W'($urandom_range(COLS_N - 1)),
                   CHAR_W'($urandom_range(255)));
   endtask

   // Drop valid and wait for every outstanding result
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // One random request; full-screen sweeps are rationed to bound run time
   task automatic send_random_request();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         put_req(CHAR_W'($urandom_range(255)));
      end else if (pick < 52) begin
         case ($urandom_range(2))
            0:       put_req(CH_TAB);
            1:       put_req(CH_NEWLINE);
            default: put_req(CH_BACKSPACE);
         endcase
      end else if (pick < 64 || (pick >= 93 && pick < 100)) begin
         // lean on columns near the right edge for tab and wrap cases
         move_req($urandom_range(ROWS - 1),
                  ($urandom_range(3) == 0) ? $urandom_range(COLS_N - 1, COLS_N - 9)
                                           : $urandom_range(COLS_N - 1));
      end else if (pick < 78) begin
         plain_req(OP_READ);
      end else if (pick < 86) begin
         plain_req(OP_CLREOL);
      end else if (pick < 89) begin
         plain_req($urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO);
      end else if (pick < 92) begin
         if (clrbot_budget > 0) begin
            clrbot_budget--;
            plain_req(OP_CLRBOT);
         end else begin
            plain_req(OP_READ);
         end
      end else begin
         if (erase_budget > 0) begin
            erase_budget--;
            plain_req(OP_ERASE);
         end else begin
            plain_req(OP_READ);
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Stored characters, column wrap and wrap from the bottom-right cell
   task automatic test_put_and_wrap();
      plain_req(OP_READ);
      put_req(8'hFF);
      put_req(8'h00);
      move_req(0, 0);
      plain_req(OP_READ);
      move_req(0, COLS_N - 2);
      put_req(8'h41);
      put_req(8'h42);
      move_req(ROWS - 1, COLS_N - 1);
      put_req(8'h5A);
   endtask

   // Tab stops and their cap, backspace at the left edge, newline wrap
   task automatic test_control_codes();
      move_req(2, COLS_N - 3);
      put_req(CH_TAB);
      put_req(CH_TAB);
      move_req(2, 3);
      put_req(CH_TAB);
      put_req(CH_BACKSPACE);
      move_req(2, 0);
      put_req(CH_BACKSPACE);
      move_req(ROWS - 1, 5);
      put_req(CH_NEWLINE);
   endtask

   // Clears, including the last column, full erase and the spare codes
   task automatic test_clears_and_spares();
      move_req(0, COLS_N - 1);
      plain_req(OP_CLREOL);
      plain_req(OP_READ);
      move_req(ROWS - 2, 10);
      plain_req(OP_CLRBOT);
      plain_req(OP_ERASE);
      plain_req(OP_READ);
      plain_req(OP_SPARE_LO);
      plain_req(OP_SPARE_HI);
      wait_drained();
   endtask

   // Hold the result side off so the console fills and stalls its input
   task automatic test_backpressure();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      long_hold_requests++;
      repeat (14) send_random_request();
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_random_request();
      wait_drained();
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_op             = OP_PUT;
      req_row            = '0;
      req_col            = '0;
      req_char_code      = '0;
      mismatch_count     = 0;
      req_idle_pct       = 0;
      rsp_stall_pct      = 0;
      long_hold_requests = 0;
      erase_budget       = 6;
      clrbot_budget      = 12;
      model_row          = 0;
      model_col          = 0;
      for (int a = 0; a < DEPTH; a++)
         screen_model[a] = '0;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_put_and_wrap();
      test_control_codes();
      test_clears_and_spares();
      test_backpressure();
      test_random_traffic(120, 0, 0);
      test_random_traffic(120, 77, 0);
      test_random_traffic(120, 0, 77);
      test_random_traffic(120, 36, 36);
      repeat (20) @(negedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         if (pending_results.size() != 0)
            $display("%0t: %0d requests never answered", $time, pending_results.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
